FILE: design/tsc_pkg.sv
// ---------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the timing sample clusterer: sequencer
// states, field widths and the fixed scale factors of the match test.
// ---------------------------------------------------------------------------
package tsc_pkg;

   // Field widths fixed by the interface
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned COUNT_W  = 32;
   localparam int unsigned PCT_W    = 7;
   localparam int unsigned SLOTID_W = 3;

   // Match test works on diff * 100 against percent * base
   localparam int unsigned PROD_W   = TIME_W + PCT_W;
   localparam logic [PCT_W-1:0] PCT_SCALE     = 7'd100;
   localparam logic [PCT_W-1:0] MATCH_PCT_RST = 7'd10;

   // Average update: 64-bit dividend, divisor up to 2^32
   localparam int unsigned SUM_W    = 64;
   localparam int unsigned DIVISOR_W = COUNT_W + 1;
   localparam int unsigned STEP_W   = 6;

   // Sequencer states
   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_LOOKUP  = 8'b0000_0010,
      ST_DIFF    = 8'b0000_0100,
      ST_COMPARE = 8'b0000_1000,
      ST_PROD    = 8'b0001_0000,
      ST_DIV     = 8'b0010_0000,
      ST_WRITE   = 8'b0100_0000,
      ST_FINISH  = 8'b1000_0000
   } state_type;

endpackage

FILE: design/timing_sample_clusterer.sv
// ---------------------------------------------------------------------------
// timing_sample_clusterer
// Groups time samples into up to SLOTS clusters of running average and
// count; each sample updates the first close cluster, opens a new one, or
// is dropped when the table is full.
// ---------------------------------------------------------------------------
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid, req_stall, req_sample_time   | in
//   rsp     | rsp_valid, rsp_stall, rsp_slot_index,   | out
//           | rsp_created_new, rsp_slot_count,        |
//           | rsp_slot_average, rsp_dropped           |
//   csr     | csr_write_enable, csr_write_data        | in
//
// Flow: a sample scans the filled clusters in order, three steps per cluster
// (read, diff*100, compare). With no match it appends a cluster or is
// dropped; with a match the average update runs the 64-step bit-serial
// divider and writes the cluster back. req_stall is high while a sample is
// in work. Reset is synchronous and empties the table. A result waits in
// the output register under rsp_stall while the next sample enters.
// ---------------------------------------------------------------------------
module timing_sample_clusterer #(
   parameter int unsigned SLOTS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tsc_pkg::TIME_W-1:0]       req_sample_time,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tsc_pkg::SLOTID_W-1:0]     rsp_slot_index,
   output logic                             rsp_created_new,
   output logic [tsc_pkg::COUNT_W-1:0]      rsp_slot_count,
   output logic [tsc_pkg::TIME_W-1:0]       rsp_slot_average,
   output logic                             rsp_dropped,
   input  logic                             csr_write_enable,
   input  logic [tsc_pkg::PCT_W-1:0]        csr_write_data
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned USED_W = $clog2(SLOTS + 1);
   localparam logic [USED_W-1:0] SLOTS_FULL = USED_W'(SLOTS);
   localparam int unsigned TW = tsc_pkg::TIME_W;
   localparam int unsigned CW = tsc_pkg::COUNT_W;

   // Cluster table
   logic [TW-1:0] avg_mem [SLOTS];
   logic [CW-1:0] cnt_mem [SLOTS];

   tsc_pkg::state_type state_ff, state_in;
   logic [USED_W-1:0]  scan_ff, scan_in;
   logic [USED_W-1:0]  used_ff, used_in;
   logic [tsc_pkg::PCT_W-1:0] match_pct_ff, match_pct_in;
   logic [TW-1:0]      time_ff, time_in;
   logic [TW-1:0]      rd_avg_ff;
   logic [CW-1:0]      rd_cnt_ff;
   logic [tsc_pkg::PROD_W-1:0] lhs_ff, lhs_in;
   logic [tsc_pkg::SUM_W-1:0] quo_ff, quo_in;
   logic [tsc_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [tsc_pkg::DIVISOR_W-1:0] div_ff, div_in;
   logic [tsc_pkg::STEP_W-1:0] step_ff, step_in;

   logic [tsc_pkg::SLOTID_W-1:0] res_slot_ff, res_slot_in;
   logic               res_new_ff, res_new_in;
   logic [CW-1:0]      res_count_ff, res_count_in;
   logic [TW-1:0]      res_avg_ff, res_avg_in;
   logic               res_drop_ff, res_drop_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [tsc_pkg::SLOTID_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic               rsp_new_ff, rsp_new_in;
   logic [CW-1:0]      rsp_count_ff, rsp_count_in;
   logic [TW-1:0]      rsp_avg_ff, rsp_avg_in;
   logic               rsp_drop_ff, rsp_drop_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [TW-1:0]      wr_avg;
   logic [CW-1:0]      wr_cnt;

   logic [TW-1:0]      base;
   logic [TW-1:0]      diff;
   logic [tsc_pkg::PROD_W-1:0] rhs;
   logic [tsc_pkg::DIVISOR_W:0] rem_shift;
   logic [tsc_pkg::DIVISOR_W:0] rem_sub;
   logic [CW-1:0]      cnt_next;
   logic [IDX_W+tsc_pkg::SLOTID_W-1:0] scan_ext;
   logic [IDX_W+tsc_pkg::SLOTID_W-1:0] used_ext;
   logic               out_free;
   logic               req_xfer;

   // Handshake
   assign req_stall = (state_ff != tsc_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Shared datapath terms
   assign base      = (rd_avg_ff == '0) ? TW'(1) : rd_avg_ff;
   assign diff      = (time_ff > rd_avg_ff) ? (time_ff - rd_avg_ff) : (rd_avg_ff - time_ff);
   assign rhs       = tsc_pkg::PROD_W'(match_pct_ff) * tsc_pkg::PROD_W'(base);
   assign rem_shift = {rem_ff, quo_ff[tsc_pkg::SUM_W-1]};
   assign rem_sub   = rem_shift - {1'b0, div_ff};
   assign cnt_next  = (rd_cnt_ff == '1) ? rd_cnt_ff : (rd_cnt_ff + CW'(1));
   assign scan_ext  = {{tsc_pkg::SLOTID_W{1'b0}}, scan_ff[IDX_W-1:0]};
   assign used_ext  = {{tsc_pkg::SLOTID_W{1'b0}}, used_ff[IDX_W-1:0]};

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      used_in      = used_ff;
      match_pct_in = match_pct_ff;
      time_in      = time_ff;
      lhs_in       = lhs_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      res_slot_in  = res_slot_ff;
      res_new_in   = res_new_ff;
      res_count_in = res_count_ff;
      res_avg_in   = res_avg_ff;
      res_drop_in  = res_drop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_count_in = rsp_count_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_drop_in  = rsp_drop_ff;
      wr_en        = 1'b0;
      wr_idx       = scan_ff[IDX_W-1:0];
      wr_avg       = quo_ff[TW-1:0];
      wr_cnt       = cnt_next;

      if (csr_write_enable) begin
         match_pct_in = csr_write_data;
      end

      // Drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         tsc_pkg::ST_IDLE: begin
            if (req_xfer) begin
               time_in  = req_sample_time;
               scan_in  = '0;
               state_in = tsc_pkg::ST_LOOKUP;
            end
         end
         tsc_pkg::ST_LOOKUP: begin
            // End of scan: append a cluster or drop the sample
            if (scan_ff == used_ff) begin
               if (used_ff == SLOTS_FULL) begin
                  res_slot_in  = '0;
                  res_new_in   = 1'b0;
                  res_count_in = '0;
                  res_avg_in   = '0;
                  res_drop_in  = 1'b1;
               end else begin
                  wr_en        = 1'b1;
                  wr_idx       = used_ff[IDX_W-1:0];
                  wr_avg       = time_ff;
                  wr_cnt       = CW'(1);
                  used_in      = used_ff + USED_W'(1);
                  res_slot_in  = used_ext[tsc_pkg::SLOTID_W-1:0];
                  res_new_in   = 1'b1;
                  res_count_in = CW'(1);
                  res_avg_in   = time_ff;
                  res_drop_in  = 1'b0;
               end
               state_in = tsc_pkg::ST_FINISH;
            end else begin
               state_in = tsc_pkg::ST_DIFF;
            end
         end
         tsc_pkg::ST_DIFF: begin
            lhs_in   = tsc_pkg::PROD_W'(diff) * tsc_pkg::PROD_W'(tsc_pkg::PCT_SCALE);
            state_in = tsc_pkg::ST_COMPARE;
         end
         tsc_pkg::ST_COMPARE: begin
            // floor(diff*100/base) < pct  <=>  diff*100 < pct*base
            if (lhs_ff < rhs) begin
               state_in = tsc_pkg::ST_PROD;
            end else begin
               scan_in  = scan_ff + USED_W'(1);
               state_in = tsc_pkg::ST_LOOKUP;
            end
         end
         tsc_pkg::ST_PROD: begin
            quo_in   = tsc_pkg::SUM_W'(base) * tsc_pkg::SUM_W'(rd_cnt_ff)
                       + tsc_pkg::SUM_W'(time_ff);
            div_in   = tsc_pkg::DIVISOR_W'(rd_cnt_ff) + tsc_pkg::DIVISOR_W'(1);
            rem_in   = '0;
            step_in  = '0;
            state_in = tsc_pkg::ST_DIV;
         end
         tsc_pkg::ST_DIV: begin
            // One restoring step per cycle, quotient shifts in from the right
            if (rem_shift >= {1'b0, div_ff}) begin
               rem_in = rem_sub[tsc_pkg::DIVISOR_W-1:0];
               quo_in = {quo_ff[tsc_pkg::SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[tsc_pkg::DIVISOR_W-1:0];
               quo_in = {quo_ff[tsc_pkg::SUM_W-2:0], 1'b0};
            end
            step_in = step_ff + tsc_pkg::STEP_W'(1);
            if (step_ff == '1) begin
               state_in = tsc_pkg::ST_WRITE;
            end
         end
         tsc_pkg::ST_WRITE: begin
            wr_en        = 1'b1;
            res_slot_in  = scan_ext[tsc_pkg::SLOTID_W-1:0];
            res_new_in   = 1'b0;
            res_count_in = cnt_next;
            res_avg_in   = quo_ff[TW-1:0];
            res_drop_in  = 1'b0;
            state_in     = tsc_pkg::ST_FINISH;
         end
         tsc_pkg::ST_FINISH: begin
            // Hand the result over once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = res_slot_ff;
               rsp_new_in   = res_new_ff;
               rsp_count_in = res_count_ff;
               rsp_avg_in   = res_avg_ff;
               rsp_drop_in  = res_drop_ff;
               state_in     = tsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsc_pkg::ST_IDLE;
         used_ff      <= '0;
         match_pct_ff <= tsc_pkg::MATCH_PCT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         match_pct_ff <= match_pct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      time_ff      <= time_in;
      lhs_ff       <= lhs_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      step_ff      <= step_in;
      res_slot_ff  <= res_slot_in;
      res_new_ff   <= res_new_in;
      res_count_ff <= res_count_in;
      res_avg_ff   <= res_avg_in;
      res_drop_ff  <= res_drop_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_count_ff <= rsp_count_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   // Cluster table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         avg_mem[wr_idx] <= wr_avg;
         cnt_mem[wr_idx] <= wr_cnt;
      end
      rd_avg_ff <= avg_mem[scan_ff[IDX_W-1:0]];
      rd_cnt_ff <= cnt_mem[scan_ff[IDX_W-1:0]];
   end

   // Outputs
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_created_new  = rsp_new_ff;
   assign rsp_slot_count   = rsp_count_ff;
   assign rsp_slot_average = rsp_avg_ff;
   assign rsp_dropped      = rsp_drop_ff;

endmodule
